/* design/keyed_usage_counter_table_assert.svh */
// Assertion macros for the keyed usage counter table checker.
// Standalone header: no dependencies.
`ifndef KEYED_USAGE_COUNTER_TABLE_ASSERT_SVH
`define KEYED_USAGE_COUNTER_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define KUCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define KUCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* design/kuct_pkg.sv */
// Shared types and constants for the keyed usage counter table.
// No dependencies.
package kuct_pkg;
	localparam int TableEntries = 1024;
	localparam int ProbeLimit   = 8;
	localparam int IdxW         = $clog2(TableEntries);
	localparam int ProbeW       = $clog2(ProbeLimit + 1);
	localparam logic [31:0] HashSeed = 32'd5381;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_CREATED = 3'd1;
	localparam logic [2:0] ST_FOUND   = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_DROPPED = 3'd4;

	localparam logic [2:0] CT_VOICE_OUT = 3'd0;
	localparam logic [2:0] CT_VOICE_IN  = 3'd1;
	localparam logic [2:0] CT_SMS_OUT   = 3'd2;
	localparam logic [2:0] CT_SMS_IN    = 3'd3;
	localparam logic [2:0] CT_DATA      = 3'd4;

	typedef struct packed {
		logic        operation;
		logic [59:0] key_bcd;
		logic [3:0]  key_digits;
		logic        same_network;
		logic [2:0]  call_type;
		logic [31:0] duration;
		logic [31:0] download_amount;
		logic [31:0] upload_amount;
	} kuct_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] voice_out_in;
		logic [31:0] voice_in_in;
		logic [31:0] voice_out_off;
		logic [31:0] voice_in_off;
		logic [31:0] sms_out_in;
		logic [31:0] sms_in_in;
		logic [31:0] sms_out_off;
		logic [31:0] sms_in_off;
		logic [31:0] download_total;
		logic [31:0] upload_total;
	} kuct_out_t;

	typedef logic [319:0] counters_t;
endpackage

/* design/keyed_usage_counter_table.sv */
// Keyed usage counter table: hashed per-key counters in a 1024-slot memory.
// Sequence: the key is hashed one digit at a time, up to ProbeLimit slots are probed
// from the hashed base, then a slot is chosen and the record is written back.
// One word at a time: busy holds from accept until the result is registered, so no
// new word is taken before the last is through. Results are never stalled.
// Reset runs a clearing pass over the valid bits and keys of all 1024 slots with busy high.
module keyed_usage_counter_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  kuct_pkg::kuct_in_t  in_word,
	output logic               result_valid,
	output kuct_pkg::kuct_out_t result
);
	import kuct_pkg::*;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_DECIDE, S_WRITE} state_t;

	state_t            state_q;
	kuct_in_t          req_q;
	logic [63:0]       key_q;
	logic [31:0]       hash_q;
	logic [3:0]        dig_q;
	logic [ProbeW-1:0] probe_q;
	logic [IdxW-1:0]   base_q;
	logic [IdxW-1:0]   clr_idx_q;
	logic              rd_pend_s1;
	logic [IdxW-1:0]   rd_idx_s1;
	logic              found_q, free_q;
	logic [IdxW-1:0]   found_idx_q, free_idx_q;
	counters_t         found_cnt_q;
	counters_t         new_cnt_q;
	logic [IdxW-1:0]   sel_q;

	// slot storage: valid bit and key in one memory, counters in another
	logic [64:0]             key_mem [TableEntries];
	counters_t               cnt_mem [TableEntries];
	logic [64:0]             key_rd_s1;
	counters_t               cnt_rd_s1;

	logic [59:0]     key_mask;
	logic [3:0]      nib;
	logic [IdxW-1:0] rd_idx;
	logic            rd_en;
	logic            wr_en;
	logic            clr_en;
	counters_t       upd;
	kuct_out_t       result_d;

	// mask of used nibbles and the current hash digit
	always_comb begin
		key_mask = '0;
		for (int i = 0; i < 15; i++) begin
			if (i < int'(in_word.key_digits)) key_mask[i*4 +: 4] = 4'hF;
		end
		nib = req_q.key_bcd[(dig_q - 4'd1) * 4 +: 4];
	end

	assign rd_en  = (state_q == S_PROBE) && (probe_q < ProbeW'(ProbeLimit));
	assign rd_idx = base_q + IdxW'(probe_q);
	assign wr_en  = (state_q == S_WRITE) && (req_q.operation == OP_UPDATE) &&
		(found_q || free_q);
	assign clr_en = (state_q == S_CLEAR);

	// memory read and write ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_s1 <= key_mem[rd_idx];
			cnt_rd_s1 <= cnt_mem[rd_idx];
		end
		if (clr_en) begin
			key_mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			key_mem[sel_q] <= {1'b1, key_q};
		end
		if (wr_en) begin
			cnt_mem[sel_q] <= new_cnt_q;
		end
	end

	// add the record to the selected counters
	always_comb begin
		logic [31:0] c [10];
		for (int i = 0; i < 10; i++) c[i] = found_q ? found_cnt_q[(9-i)*32 +: 32] : 32'd0;
		if (req_q.same_network) begin
			case (req_q.call_type)
				CT_VOICE_OUT: c[0] = c[0] + req_q.duration;
				CT_VOICE_IN:  c[1] = c[1] + req_q.duration;
				CT_SMS_OUT:   c[4] = c[4] + 32'd1;
				CT_SMS_IN:    c[5] = c[5] + 32'd1;
				default: ;
			endcase
		end else begin
			case (req_q.call_type)
				CT_VOICE_OUT: c[2] = c[2] + req_q.duration;
				CT_VOICE_IN:  c[3] = c[3] + req_q.duration;
				CT_SMS_OUT:   c[6] = c[6] + 32'd1;
				CT_SMS_IN:    c[7] = c[7] + 32'd1;
				CT_DATA: begin
					c[8] = c[8] + req_q.download_amount;
					c[9] = c[9] + req_q.upload_amount;
				end
				default: ;
			endcase
		end
		for (int i = 0; i < 10; i++) upd[(9-i)*32 +: 32] = c[i];
	end

	// build the result word for the write-back cycle
	always_comb begin
		result_d = '0;
		if (req_q.operation == OP_QUERY) begin
			if (found_q) begin
				result_d.status = ST_FOUND;
				{result_d.voice_out_in, result_d.voice_in_in, result_d.voice_out_off,
					result_d.voice_in_off, result_d.sms_out_in, result_d.sms_in_in,
					result_d.sms_out_off, result_d.sms_in_off, result_d.download_total,
					result_d.upload_total} = found_cnt_q;
			end else begin
				result_d.status = ST_MISSING;
			end
		end else if (found_q || free_q) begin
			result_d.status = found_q ? ST_UPDATED : ST_CREATED;
			{result_d.voice_out_in, result_d.voice_in_in, result_d.voice_out_off,
				result_d.voice_in_off, result_d.sms_out_in, result_d.sms_in_in,
				result_d.sms_out_off, result_d.sms_in_off, result_d.download_total,
				result_d.upload_total} = new_cnt_q;
		end else begin
			result_d.status = ST_DROPPED;
		end
	end

	// sequencer: clear, hash, probe, decide, write back, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			rd_pend_s1   <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == S_WRITE);
			rd_pend_s1   <= rd_en;
			rd_idx_s1    <= rd_idx;
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IdxW'(1);
					if (clr_idx_q == IdxW'(TableEntries - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						req_q   <= in_word;
						key_q   <= {in_word.key_digits, in_word.key_bcd & key_mask};
						hash_q  <= HashSeed;
						dig_q   <= in_word.key_digits;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (dig_q == 4'd0) begin
						base_q  <= hash_q[IdxW-1:0];
						probe_q <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_PROBE;
					end else begin
						hash_q <= (hash_q << 5) + hash_q + 32'h30 + {28'd0, nib};
						dig_q  <= dig_q - 4'd1;
					end
				end
				S_PROBE: begin
					if (rd_en) probe_q <= probe_q + ProbeW'(1);
					if (rd_pend_s1) begin
						if (key_rd_s1[64]) begin
							if (!found_q && key_rd_s1[63:0] == key_q) begin
								found_q     <= 1'b1;
								found_idx_q <= rd_idx_s1;
								found_cnt_q <= cnt_rd_s1;
							end
						end else if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
					end
					if (!rd_en && !rd_pend_s1) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					sel_q     <= found_q ? found_idx_q : free_idx_q;
					new_cnt_q <= upd;
					state_q   <= S_WRITE;
				end
				S_WRITE: begin
					result  <= result_d;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

/* design/kuct_checker.sv */
// Port-level checker for the keyed usage counter table, bound to the top level.
// Depends on kuct_pkg and keyed_usage_counter_table_assert.svh.
`include "keyed_usage_counter_table_assert.svh"
module kuct_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input kuct_pkg::kuct_out_t result
);
	import kuct_pkg::*;

	`KUCT_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "no busy after accept")
	`KUCT_ASSERT_IMP(a_strobe_busy, clk, arst_n, result_valid, $past(busy), "strobe without work")
	`KUCT_ASSERT_NXT(a_strobe_single, clk, arst_n, result_valid, !result_valid, "double strobe")
	`KUCT_ASSERT_IMP(a_status_range, clk, arst_n, result_valid, result.status <= ST_DROPPED, "bad status")
	`KUCT_ASSERT_IMP(a_miss_zero, clk, arst_n, result_valid && (result.status == ST_MISSING || result.status == ST_DROPPED), result.upload_total == 32'd0 && result.voice_out_in == 32'd0, "nonzero on miss")
endmodule

bind keyed_usage_counter_table kuct_checker u_kuct_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.result_valid(result_valid), .result(result)
);
